// ----- hdl/plp_pkg.sv -----
// Package for the point-to-line projection parameter block.
// Holds payload structs, widths and defaults; no dependencies.
`timescale 1ns / 1ps
package plp_pkg;
  localparam int unsigned CoordW = 24;
  localparam int unsigned ThreshW = 52;
  localparam int unsigned ParamW = 32;
  localparam int unsigned CoordFracBitsDef = 12;
  localparam int unsigned OutFracBitsDef = 16;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } query_t;

  typedef struct packed {
    logic signed [ParamW-1:0] line_param;
    logic                     degenerate;
    logic                     saturated;
  } result_t;

  // Classified item passed from the front part to the divider.
  typedef struct packed {
    logic        degenerate;
    logic        neg;
    logic [51:0] mag;
    logic [51:0] nsq;
  } job_t;
endpackage

// ----- hdl/plp_front.sv -----
// Front part: differences, dot product and squared length, degeneracy check.
// Depends on plp_pkg. Fully pipelined, three register stages.
`timescale 1ns / 1ps
module plp_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  plp_pkg::query_t                   query_i,
  input  logic [plp_pkg::ThreshW-1:0]       threshold_i,
  output logic                              job_valid_o,
  output plp_pkg::job_t                     job_o
);
  localparam int unsigned ParamMagW = 52;
  logic signed [24:0] e_q [3];
  logic signed [24:0] d_q [3];
  logic signed [49:0] pd_q [3];
  logic signed [49:0] pe_q [3];
  logic [2:0] v_q;
  logic signed [52:0] dot_d;
  logic [51:0] nsq_d;
  logic [ParamMagW-1:0] mag_d;

  always_comb begin
    dot_d = 53'(pd_q[0]) + 53'(pd_q[1]) + 53'(pd_q[2]);
    nsq_d = 52'(pe_q[0]) + 52'(pe_q[1]) + 52'(pe_q[2]);
    mag_d = dot_d[52] ? 52'(-dot_d) : 52'(dot_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    e_q[0] <= 25'(query_i.end_x) - 25'(query_i.start_x);
    e_q[1] <= 25'(query_i.end_y) - 25'(query_i.start_y);
    e_q[2] <= 25'(query_i.end_z) - 25'(query_i.start_z);
    d_q[0] <= 25'(query_i.point_x) - 25'(query_i.start_x);
    d_q[1] <= 25'(query_i.point_y) - 25'(query_i.start_y);
    d_q[2] <= 25'(query_i.point_z) - 25'(query_i.start_z);
    for (int i = 0; i < 3; i++) begin
      pd_q[i] <= d_q[i] * e_q[i];
      pe_q[i] <= e_q[i] * e_q[i];
    end
    job_o.degenerate <= (nsq_d == '0) || (nsq_d < threshold_i);
    job_o.neg        <= dot_d[52];
    job_o.mag        <= mag_d;
    job_o.nsq        <= nsq_d;
  end

  assign job_valid_o = v_q[2];
endmodule

// ----- hdl/plp_queue.sv -----
// Short queue between the front part and the divider.
// Depends on plp_pkg.
`timescale 1ns / 1ps
module plp_queue #(
  parameter int unsigned Depth = plp_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  plp_pkg::job_t data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output plp_pkg::job_t data_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  plp_pkg::job_t mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (32'(p) == Depth - 1) ? '0 : AW'(32'(p) + 1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= inc(wp_q);
      if (pop_i && valid_o) rp_q <= inc(rp_q);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i && valid_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  assign valid_o = cnt_q != '0;
  assign data_o = mem_q[rp_q];
endmodule

// ----- hdl/plp_back.sv -----
// Back part: pipelined restoring divider, one quotient bit per stage,
// with saturation and result formatting. Depends on plp_pkg.
`timescale 1ns / 1ps
module plp_back #(
  parameter int unsigned OutFracBits = plp_pkg::OutFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  plp_pkg::job_t     job_i,
  output logic              res_valid_o,
  output plp_pkg::result_t  res_o
);
  // Integer quotient bits beyond 33 - OutFracBits all mean saturation.
  localparam int unsigned IntBits = 33 - OutFracBits;
  localparam int unsigned QW = IntBits + OutFracBits;
  localparam int unsigned NS = QW;
  localparam int unsigned ParamW = plp_pkg::ParamW;

  typedef struct packed {
    logic        v;
    logic        degenerate;
    logic        neg;
    logic        big;
    logic [52:0] rem;
    logic [51:0] nsq;
    logic [51:0] num;
    logic [QW-1:0] quo;
  } st_t;

  st_t s_q [NS+1];
  st_t s_d [NS+1];
  logic signed [ParamW-1:0] pm;
  logic [QW-1:0] lim;
  logic sat;

  always_comb begin
    s_d[0].v = job_valid_i;
    s_d[0].degenerate = job_i.degenerate;
    s_d[0].neg = job_i.neg;
    s_d[0].nsq = job_i.nsq;
    // q >= 2^IntBits ends in saturation, so only the low integer bits divide.
    s_d[0].big = ((job_i.mag >> IntBits) >= job_i.nsq);
    s_d[0].rem = 53'(job_i.mag >> IntBits);
    s_d[0].num = job_i.mag << (52 - IntBits);
    s_d[0].quo = '0;
    for (int k = 1; k <= NS; k++) begin
      s_d[k] = s_q[k-1];
      begin
        logic [52:0] t;
        t = (k <= IntBits) ? {s_q[k-1].rem[51:0], s_q[k-1].num[51]}
                           : {s_q[k-1].rem[51:0], 1'b0};
        s_d[k].num = s_q[k-1].num << 1;
        if (t >= {1'b0, s_q[k-1].nsq}) begin
          s_d[k].rem = t - {1'b0, s_q[k-1].nsq};
          s_d[k].quo = {s_q[k-1].quo[QW-2:0], 1'b1};
        end else begin
          s_d[k].rem = t;
          s_d[k].quo = {s_q[k-1].quo[QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) s_q[k].v <= 1'b0;
    end else begin
      for (int k = 0; k <= NS; k++) s_q[k] <= s_d[k];
    end
  end

  always_comb begin
    lim = s_q[NS].neg ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    sat = s_q[NS].big || (s_q[NS].quo > lim);
    pm = ParamW'(sat ? lim : s_q[NS].quo);
    if (s_q[NS].neg) pm = -pm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
    end else begin
      res_valid_o <= s_q[NS].v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_q[NS].degenerate) begin
      res_o.line_param <= -(ParamW'(1) << OutFracBits);
      res_o.degenerate <= 1'b1;
      res_o.saturated  <= 1'b0;
    end else begin
      res_o.line_param <= pm;
      res_o.degenerate <= 1'b0;
      res_o.saturated  <= sat;
    end
  end
endmodule

// ----- hdl/point_line_projection_param_top.sv -----
// Top level of the point-to-line projection parameter block.
// Pipeline: 3 front stages, the queue, 34 divider stages, 1 output stage.
// Throughput: one item per cycle; busy stays low since the divider never stalls.
// The divider pipeline, one quotient bit per stage, accounts for most of the latency.
// Reset clears all valid bits and sets the threshold to 1.
// Depends on plp_pkg, plp_front, plp_queue and plp_back.
`timescale 1ns / 1ps
module point_line_projection_param_top #(
  parameter int unsigned OutFracBits = plp_pkg::OutFracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  plp_pkg::query_t             query_i,
  output logic                        result_valid_o,
  output plp_pkg::result_t            result_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [plp_pkg::ThreshW-1:0] cfg_data_i
);
  logic [plp_pkg::ThreshW-1:0] thr_q;
  logic jv, qv;
  plp_pkg::job_t job, qjob;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= plp_pkg::ThreshW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_data_i;
    end
  end

  plp_front u_front (
    .clk_i, .rst_ni, .in_valid_i(start && !busy), .query_i,
    .threshold_i(thr_q), .job_valid_o(jv), .job_o(job)
  );

  plp_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .data_i(job), .pop_i(1'b1),
    .valid_o(qv), .data_o(qjob)
  );

  plp_back #(.OutFracBits(OutFracBits)) u_back (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(qjob),
    .res_valid_o(result_valid_o), .res_o(result_o)
  );

  a_degen_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.degenerate |->
      !result_o.saturated && result_o.line_param == -(32'sd1 <<< OutFracBits))
    else $error("degenerate result malformed");
  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> thr_q == $past(cfg_data_i))
    else $error("threshold write lost");
endmodule

// ----- tb/point_line_projection_param_top_test.sv -----
// Self-checking testbench for the point-to-line projection parameter block.
// Drives query transfers, predicts each result and compares it with the output stream.
// Depends on plp_pkg and point_line_projection_param_top.
`timescale 1ns / 1ps
module point_line_projection_param_top_test;
  localparam int unsigned FracBits = plp_pkg::OutFracBitsDef;
  localparam int unsigned CoordW = plp_pkg::CoordW;
  localparam int unsigned ThreshW = plp_pkg::ThreshW;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned StallLimit = 5000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  plp_pkg::query_t      query_i = '0;
  logic                 result_valid_o;
  plp_pkg::result_t     result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [ThreshW-1:0]   cfg_data_i = '0;

  plp_pkg::query_t      pending_q[$];
  plp_pkg::result_t     expected_q[$];
  logic [ThreshW-1:0]   threshold = 1;
  int                   n_errors = 0;
  int                   n_queries = 0;
  int                   n_results = 0;
  int                   n_degenerate = 0;
  int                   n_saturated = 0;
  int                   burst_left = 0;
  int                   gap_left = 0;
  int                   idle_cycles = 0;

  point_line_projection_param_top dut (
    .clk_i, .rst_ni, .start, .busy, .query_i, .result_valid_o, .result_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic plp_pkg::result_t project_param(plp_pkg::query_t q);
    longint             e[3], d[3];
    longint             dot;
    longint unsigned    nsq, mag, quo, rem, frac, lim, m;
    bit                 neg, sat;
    plp_pkg::result_t   r;
    e[0] = longint'(q.end_x) - longint'(q.start_x);
    e[1] = longint'(q.end_y) - longint'(q.start_y);
    e[2] = longint'(q.end_z) - longint'(q.start_z);
    d[0] = longint'(q.point_x) - longint'(q.start_x);
    d[1] = longint'(q.point_y) - longint'(q.start_y);
    d[2] = longint'(q.point_z) - longint'(q.start_z);
    dot = 0;
    nsq = 0;
    for (int i = 0; i < 3; i++) begin
      dot += d[i] * e[i];
      nsq += longint'(e[i] * e[i]);
    end
    if (nsq == 0 || nsq < {12'd0, threshold}) begin
      r.line_param = -(32'sd1 <<< FracBits);
      r.degenerate = 1'b1;
      r.saturated = 1'b0;
      return r;
    end
    neg = dot < 0;
    mag = neg ? -dot : dot;
    quo = mag / nsq;
    rem = mag % nsq;
    frac = 0;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    sat = 1'b0;
    for (int i = 0; i < FracBits; i++) begin
      rem = rem << 1;
      frac = frac << 1;
      if (rem >= nsq) begin
        rem -= nsq;
        frac |= 1;
      end
    end
    if (quo > (64'd1 << (32 - FracBits))) begin
      m = lim;
      sat = 1'b1;
    end else begin
      m = (quo << FracBits) | frac;
      if (m > lim) begin
        m = lim;
        sat = 1'b1;
      end
    end
    r.line_param = neg ? 32'(-m) : 32'(m);
    r.degenerate = 1'b0;
    r.saturated = sat;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        expected_q = {expected_q, project_param(query_i)};
        void'(pending_q.pop_front());
        n_queries++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          next_start = 1'b1;
          query_i <= pending_q[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
          end
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk_i) begin
    plp_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, result_o);
        n_errors++;
      end else begin
        want = expected_q.pop_front();
        if (want.degenerate) n_degenerate++;
        if (want.saturated) n_saturated++;
        if (result_o.line_param !== want.line_param) begin
          $display("%0t: line_param expected %h actual %h", $time, want.line_param,
                   result_o.line_param);
          n_errors++;
        end
        if (result_o.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                   result_o.degenerate);
          n_errors++;
        end
        if (result_o.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   result_o.saturated);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("point_line_projection_param_top_test: errors");
      $finish;
    end
  end

  function automatic logic signed [CoordW-1:0] rand_coord();
    return CoordW'($urandom);
  endfunction

  function automatic logic signed [CoordW-1:0] near(logic signed [CoordW-1:0] c, int span);
    return c + CoordW'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_query(input logic signed [CoordW-1:0] ax, ay, az, bx, by, bz,
                           px, py, pz);
    plp_pkg::query_t q;
    q = '{ax, ay, az, bx, by, bz, px, py, pz};
    pending_q = {pending_q, q};
  endtask

  task automatic add_random(input int count);
    logic signed [CoordW-1:0] ax, ay, az, bx, by, bz;
    int kind, span;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      ax = rand_coord(); ay = rand_coord(); az = rand_coord();
      span = kind < 3 ? 8 : kind < 6 ? 4096 : 1 << 20;
      bx = near(ax, span); by = near(ay, span); bz = near(az, span);
      case (kind) inside
        [0:2]: begin
          add_query(ax, ay, az, bx, by, bz, near(ax, 1 << 22), near(ay, 1 << 22),
                    near(az, 1 << 22));
        end
        [3:6]: begin
          add_query(ax, ay, az, bx, by, bz, near(bx, span), near(by, span), near(bz, span));
        end
        7: begin
          add_query(ax, ay, az, ax, ay, az, rand_coord(), rand_coord(), rand_coord());
        end
        default: begin
          add_query(ax, ay, az, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord());
        end
      endcase
    end
  endtask

  task automatic wait_idle();
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThreshW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    threshold = value;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= ThreshW'($urandom);
  endtask

  localparam logic signed [CoordW-1:0] CMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] CMin = -24'sh800000;
  localparam logic signed [CoordW-1:0] One = 24'sh001000;

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed queries at the reset threshold.
    add_query(0, 0, 0, One, 0, 0, One, 0, 0);
    add_query(0, 0, 0, One, 0, 0, 0, One, 0);
    add_query(0, 0, 0, One, One, One, -One, -One, -One);
    add_query(5, 6, 7, 5, 6, 7, CMax, CMin, 0);
    add_query(0, 0, 0, 1, 0, 0, CMax, 0, 0);
    add_query(0, 0, 0, 1, 0, 0, CMin, 0, 0);
    add_query(CMin, CMin, CMin, CMax, CMax, CMax, CMax, CMax, CMax);
    add_query(CMax, CMax, CMax, CMin, CMin, CMin, CMin, CMax, CMin);
    add_query(CMin, CMax, CMin, CMax, CMin, CMax, CMax, CMax, CMax);
    add_query(0, 0, 0, 0, 0, 1, 0, 0, 24'sh010000);
    add_query(0, 0, 0, 0, 0, 1, 0, 0, 24'sh010001);
    add_query(0, 0, 0, 0, 0, 1, 0, 0, -24'sh010000);
    add_query(0, 0, 0, 0, 0, 1, 0, 0, -24'sh010001);
    add_query(0, 0, 0, 0, 3, 0, 0, 1, 0);
    add_query(0, 0, 0, 0, -3, 0, 0, 1, 0);
    add_query(CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax, CMax);
    add_random(200);
    wait_idle();
    write_threshold('0);
    add_query(1, 2, 3, 1, 2, 3, 4, 5, 6);
    add_query(CMin, CMin, CMin, CMin, CMin, CMin, CMax, CMax, CMax);
    add_random(100);
    wait_idle();
    write_threshold({ThreshW{1'b1}});
    add_query(CMin, CMin, CMin, CMax, CMax, CMax, 0, 0, 0);
    add_random(60);
    wait_idle();
    write_threshold(ThreshW'(64'd1 << 30));
    add_random(150);
    wait_idle();
    write_threshold(ThreshW'({$urandom, $urandom}) >> $urandom_range(0, 40));
    add_random(140);
    wait_idle();
    $display("Ran %0d queries and checked %0d results across 5 threshold settings.",
             n_queries, n_results);
    $display("Degenerate lines: %0d, saturated quotients: %0d.", n_degenerate, n_saturated);
    if (n_errors == 0) begin
      $display("point_line_projection_param_top_test: clean");
    end else begin
      $display("point_line_projection_param_top_test: errors");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/plp_pkg.sv
hdl/plp_front.sv
hdl/plp_queue.sv
hdl/plp_back.sv
hdl/point_line_projection_param_top.sv
tb/point_line_projection_param_top_test.sv
